// ===== design/vr2d_pkg.sv =====
package vr2d_pkg;

  // Width of the CORDIC datapath: Q2.30 coordinates plus headroom, and z.
  localparam int CW = 34;

  localparam logic signed [CW-1:0] UNIT_Q30 = CW'(64'sd1073741824);

  // atan(2^-i) in binary-angle units, 2^32 per turn.
  localparam logic [31:0] ARC_TABLE [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } vr2d_vec_t;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [1:0]         quad;
    logic               last;
  } vr2d_pay_t;

  // Elaboration-time helpers for the gain constant.
  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] root;
    logic [63:0] bitv;
    n    = n_in;
    root = '0;
    bitv = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (bitv > n) bitv = bitv >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (bitv != 0) begin
        if (n >= root + bitv) begin
          n    = n - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return root;
  endfunction

  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[62:0], num[k]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[k] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] gain_q30(input int steps);
    logic [63:0] g;
    logic [63:0] s;
    g = 64'd1 << 60;
    for (int i = 0; i < 32; i++) begin
      if (i < steps) g = g + (g >> (2 * i));
    end
    s = isqrt64(g);
    if (s == 0) s = 64'd1;
    return udiv64((64'd1 << 60) + (s >> 1), s);
  endfunction

endpackage

// ===== design/vector_rotate_2d_unit.sv =====
// Planar vector rotation by a binary angle, CORDIC chain plus product stage.
// Pipeline: one register per CORDIC cell, then clamp/fold, multiply and
//   round/saturate stages; the whole pipe advances on a single enable.
// Throughput: one transaction per cycle while the output is empty or taken.
// Reset (rst, synchronous, active high) drops every valid bit; payload is not cleared.
module vector_rotate_2d_unit #(
  parameter int ROTATION_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic [31:0]        turn_angle,
  input  logic               batch_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] rot_x,
  output logic signed [31:0] rot_y,
  output logic               result_last
);
  import vr2d_pkg::*;

  // Start vector: x = K (gain-compensated unit), y = 0.
  localparam logic signed [CW-1:0] K_INIT = CW'(gain_q30(ROTATION_STEPS));

  logic                     en;
  logic [31:0]              ang_bias;
  logic [1:0]               quad;
  logic [31:0]              resid;
  logic [ROTATION_STEPS:0]  stage_valid;
  vr2d_vec_t                stage_vec [ROTATION_STEPS+1];
  vr2d_pay_t                stage_pay [ROTATION_STEPS+1];

  // Advance the whole pipe unless the output register holds an untaken result.
  assign en       = ~out_valid | out_ready;
  assign in_ready = en;

  // Split the angle into a quarter-turn index and a signed residual in [-2^29, 2^29).
  assign ang_bias = turn_angle + 32'h2000_0000;
  assign quad     = ang_bias[31:30];
  assign resid    = turn_angle - {quad, 30'd0};

  assign stage_valid[0]     = in_valid;
  assign stage_vec[0].x     = K_INIT;
  assign stage_vec[0].y     = '0;
  assign stage_vec[0].z     = CW'(signed'(resid));
  assign stage_pay[0].vel_x = vel_x;
  assign stage_pay[0].vel_y = vel_y;
  assign stage_pay[0].quad  = quad;
  assign stage_pay[0].last  = batch_last;

  // Chain of micro-rotation cells, one per CORDIC step.
  for (genvar g = 0; g < ROTATION_STEPS; g++) begin : g_cell
    vr2d_cell #(
      .STEP(g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (stage_valid[g]),
      .in_vec   (stage_vec[g]),
      .in_pay   (stage_pay[g]),
      .out_valid(stage_valid[g+1]),
      .out_vec  (stage_vec[g+1]),
      .out_pay  (stage_pay[g+1])
    );
  end

  // Clamp, fold by quadrant, apply to the velocity, round and saturate.
  vr2d_mix u_mix (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (stage_valid[ROTATION_STEPS]),
    .in_vec     (stage_vec[ROTATION_STEPS]),
    .in_pay     (stage_pay[ROTATION_STEPS]),
    .out_valid  (out_valid),
    .rot_x      (rot_x),
    .rot_y      (rot_y),
    .result_last(result_last)
  );

  // An accepted transaction lands in the first cell.
  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> stage_valid[1])
    else $error("accepted transaction missing from first cell");

  // A stall freezes the occupancy of the cell chain.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !in_ready |=> $stable(stage_valid[ROTATION_STEPS:1]))
    else $error("cell chain moved during stall");

  // Reset empties the pipe.
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && (stage_valid[ROTATION_STEPS:1] == '0))
    else $error("pipe not empty after reset");

endmodule

// ===== design/vr2d_cell.sv =====
module vr2d_cell #(
  parameter int STEP = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  vr2d_pkg::vr2d_vec_t in_vec,
  input  vr2d_pkg::vr2d_pay_t in_pay,
  output logic              out_valid,
  output vr2d_pkg::vr2d_vec_t out_vec,
  output vr2d_pkg::vr2d_pay_t out_pay
);
  import vr2d_pkg::*;

  localparam logic signed [CW-1:0] ARC = CW'(ARC_TABLE[STEP]);

  logic signed [CW-1:0] x, y, z, xs, ys;
  logic                 fwd;
  vr2d_vec_t            vec_next;

  assign x   = in_vec.x;
  assign y   = in_vec.y;
  assign z   = in_vec.z;
  assign xs  = x >>> STEP;
  assign ys  = y >>> STEP;
  assign fwd = ~z[CW-1];

  // One micro-rotation: turn toward zero residual angle.
  always_comb begin
    if (fwd) begin
      vec_next.x = x - ys;
      vec_next.y = y + xs;
      vec_next.z = z - ARC;
    end else begin
      vec_next.x = x + ys;
      vec_next.y = y - xs;
      vec_next.z = z + ARC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_vec <= vec_next;
      out_pay <= in_pay;
    end
  end

endmodule

// ===== design/vr2d_mix.sv =====
module vr2d_mix (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  vr2d_pkg::vr2d_vec_t in_vec,
  input  vr2d_pkg::vr2d_pay_t in_pay,
  output logic               out_valid,
  output logic signed [31:0] rot_x,
  output logic signed [31:0] rot_y,
  output logic               result_last
);
  import vr2d_pkg::*;

  localparam logic signed [64:0] SAT_MAX = 65'sd2147483647;
  localparam logic signed [64:0] SAT_MIN = -65'sd2147483648;
  localparam logic signed [64:0] HALF    = 65'sd536870912;

  // Stage 1: clamp and quarter-turn fold.
  logic signed [CW-1:0] c0, s0, c1, s1;
  logic signed [31:0]   cos_q, sin_q;
  logic                 v1, v2;
  vr2d_pay_t            pay1;
  logic                 last2;

  always_comb begin
    c0 = in_vec.x;
    s0 = in_vec.y;
    if (c0 > UNIT_Q30) c0 = UNIT_Q30;
    else if (c0 < -UNIT_Q30) c0 = -UNIT_Q30;
    if (s0 > UNIT_Q30) s0 = UNIT_Q30;
    else if (s0 < -UNIT_Q30) s0 = -UNIT_Q30;
    unique case (in_pay.quad)
      2'd1: begin
        c1 = -s0;
        s1 = c0;
      end
      2'd2: begin
        c1 = -c0;
        s1 = -s0;
      end
      2'd3: begin
        c1 = s0;
        s1 = -c0;
      end
      default: begin
        c1 = c0;
        s1 = s0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q <= c1[31:0];
      sin_q <= s1[31:0];
      pay1  <= in_pay;
    end
  end

  // Stage 2: four products.
  logic signed [63:0] p_xc, p_ys, p_xs, p_yc;

  always_ff @(posedge clk) begin
    if (en) begin
      p_xc  <= pay1.vel_x * cos_q;
      p_ys  <= pay1.vel_y * sin_q;
      p_xs  <= pay1.vel_x * sin_q;
      p_yc  <= pay1.vel_y * cos_q;
      last2 <= pay1.last;
    end
  end

  // Stage 3: sum, round half up, saturate.
  logic signed [64:0] sum_x, sum_y, sh_x, sh_y;
  logic signed [31:0] sat_x, sat_y;

  always_comb begin
    sum_x = {p_xc[63], p_xc} - {p_ys[63], p_ys} + HALF;
    sum_y = {p_xs[63], p_xs} + {p_yc[63], p_yc} + HALF;
    sh_x  = sum_x >>> 30;
    sh_y  = sum_y >>> 30;
    if (sh_x > SAT_MAX) sat_x = SAT_MAX[31:0];
    else if (sh_x < SAT_MIN) sat_x = SAT_MIN[31:0];
    else sat_x = sh_x[31:0];
    if (sh_y > SAT_MAX) sat_y = SAT_MAX[31:0];
    else if (sh_y < SAT_MIN) sat_y = SAT_MIN[31:0];
    else sat_y = sh_y[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_x       <= sat_x;
      rot_y       <= sat_y;
      result_last <= last2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

endmodule

// ===== tb/sv/vector_rotate_2d_unit_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the planar vector rotation unit.
// Every accepted transaction is predicted on the spot and queued. Each result
// transaction is checked against the oldest prediction.
module vector_rotate_2d_unit_tb;

  // Match the DUT configuration; the predictor runs the same number of steps.
  localparam int STEPS        = 24;
  // DUT pipe depth: one register per CORDIC cell plus the mix stages.
  localparam int PIPE_LATENCY = STEPS + 3;
  localparam int TAIL_CYCLES  = 2 * PIPE_LATENCY + 10;
  // Watchdog limit, set well beyond the slowest legal run.
  localparam int CYCLE_LIMIT  = 400000;

  localparam logic signed [63:0] UNIT_Q30 = 64'sd1073741824;
  localparam logic signed [63:0] HALF_Q30 = 64'sd536870912;
  localparam logic signed [63:0] SAT_HI   = 64'sd2147483647;
  localparam logic signed [63:0] SAT_LO   = -64'sd2147483648;

  localparam logic [31:0] EIGHTH_TURN  = 32'h2000_0000;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

  localparam logic signed [31:0] VEL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VEL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;

  // atan(2^-i) expressed in binary-angle units (2^32 per turn).
  localparam logic [31:0] ARCTAN_UNITS [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_CHOPPY,
    RX_PERIODIC
  } rx_mode_e;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               last;
  } rotated_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] vel_x = '0;
  logic signed [31:0] vel_y = '0;
  logic [31:0]        turn_angle = '0;
  logic               batch_last = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] rot_x;
  logic signed [31:0] rot_y;
  logic               result_last;

  rotated_t           rotations_due [$];
  logic signed [63:0] gain_k;
  int                 mismatch_count = 0;
  int                 cycle_count = 0;

  // Sender burst shaping: gap_limit of zero means back-to-back transactions.
  int                 gap_limit = 0;
  int                 burst_limit = 1;
  int                 burst_left = 0;

  // Receiver pattern state.
  rx_mode_e           rx_mode = RX_ALWAYS;
  int                 rx_stall_left = 0;

  vector_rotate_2d_unit #(
    .ROTATION_STEPS (STEPS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .vel_x       (vel_x),
    .vel_y       (vel_y),
    .turn_angle  (turn_angle),
    .batch_last  (batch_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .rot_x       (rot_x),
    .rot_y       (rot_y),
    .result_last (result_last)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // CORDIC gain compensation in Q30: accumulate the squared gain in Q60,
  // take its integer square root bit by bit, then divide with rounding.
  function automatic logic signed [63:0] cordic_gain();
    logic [63:0] gain_sq;
    logic [63:0] root;
    logic [63:0] trial;
    gain_sq = 64'd1 << 60;
    for (int i = 0; i < STEPS; i++) gain_sq = gain_sq + (gain_sq >> (2 * i));
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= gain_sq) root = trial;
    end
    if (root == 0) root = 64'd1;
    return ((64'd1 << 60) + (root >> 1)) / root;
  endfunction

  // Round to nearest (ties up) from Q30 scale, then clamp to 32 bits.
  function automatic logic signed [31:0] round_saturate(input logic signed [63:0] v);
    logic signed [63:0] q;
    q = (v + HALF_Q30) >>> 30;
    if (q > SAT_HI) q = SAT_HI;
    if (q < SAT_LO) q = SAT_LO;
    return q[31:0];
  endfunction

  // Expected result of one transaction: fold the angle to a quarter turn,
  // run the CORDIC for cos/sin, unfold, then form the rotated products.
  function automatic rotated_t predict_rotation(input logic signed [31:0] vx,
                                                input logic signed [31:0] vy,
                                                input logic [31:0]        ang,
                                                input logic               lst);
    logic [31:0]        biased;
    logic [31:0]        resid;
    logic [1:0]         quadrant;
    logic signed [63:0] px;
    logic signed [63:0] py;
    logic signed [63:0] nx;
    logic signed [63:0] zr;
    logic signed [63:0] cos_v;
    logic signed [63:0] sin_v;
    logic signed [63:0] swap;
    logic signed [63:0] wide_x;
    logic signed [63:0] wide_y;
    rotated_t           res;
    biased   = ang + EIGHTH_TURN;
    quadrant = biased[31:30];
    resid    = ang - {quadrant, 30'd0};
    zr       = {{32{resid[31]}}, resid};
    px       = gain_k;
    py       = '0;
    for (int i = 0; i < STEPS; i++) begin
      if (zr >= 0) begin
        nx = px - (py >>> i);
        py = py + (px >>> i);
        zr = zr - $signed({32'd0, ARCTAN_UNITS[i]});
      end else begin
        nx = px + (py >>> i);
        py = py - (px >>> i);
        zr = zr + $signed({32'd0, ARCTAN_UNITS[i]});
      end
      px = nx;
    end
    cos_v = (px > UNIT_Q30) ? UNIT_Q30 : ((px < -UNIT_Q30) ? -UNIT_Q30 : px);
    sin_v = (py > UNIT_Q30) ? UNIT_Q30 : ((py < -UNIT_Q30) ? -UNIT_Q30 : py);
    // Turn by whole quarter turns exactly.
    case (quadrant)
      2'd1: begin
        swap  = cos_v;
        cos_v = -sin_v;
        sin_v = swap;
      end
      2'd2: begin
        cos_v = -cos_v;
        sin_v = -sin_v;
      end
      2'd3: begin
        swap  = cos_v;
        cos_v = sin_v;
        sin_v = -swap;
      end
      default: ;
    endcase
    wide_x   = 64'(vx);
    wide_y   = 64'(vy);
    res.x    = round_saturate(wide_x * cos_v - wide_y * sin_v);
    res.y    = round_saturate(wide_x * sin_v + wide_y * cos_v);
    res.last = lst;
    return res;
  endfunction

  // Print one line per mismatch and count it.
  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Drive one body and hold it until the DUT takes it. Open a new burst with a
  // random gap when the current one runs out. Call only right after a rising edge.
  task automatic send_body(input logic signed [31:0] vx, input logic signed [31:0] vy,
                           input logic [31:0] ang, input logic lst);
    int gap;
    if (gap_limit > 0 && burst_left == 0) begin
      // Now and then leave a longer gap, so the pipe can drain.
      gap        = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 1)
                                               : $urandom_range(gap_limit, 0);
      burst_left = $urandom_range(burst_limit, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_valid   <= 1'b1;
    vel_x      <= vx;
    vel_y      <= vy;
    turn_angle <= ang;
    batch_last <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rotations_due.push_back(predict_rotation(vx, vy, ang, lst));
  endtask

  // Mix full-range values with extremes and small magnitudes near zero.
  function automatic logic signed [31:0] pick_velocity();
    logic [15:0] low16;
    logic [23:0] low24;
    low16 = 16'($urandom);
    low24 = 24'($urandom);
    case ($urandom_range(7, 0))
      0: begin
        case ($urandom_range(3, 0))
          0: return VEL_MIN;
          1: return VEL_MAX;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      1, 2: return {{16{low16[15]}}, low16};
      3: return {{8{low24[23]}}, low24};
      default: return $urandom;
    endcase
  endfunction

  // Favor the quarter-turn fold points and the axes, where rounding of the
  // angle reduction matters most.
  function automatic logic [31:0] pick_angle();
    logic [31:0] base;
    base = {2'($urandom_range(3, 0)), 30'd0};
    case ($urandom_range(5, 0))
      0: return base + EIGHTH_TURN + $urandom_range(8, 0) - 32'd4;
      1: return base + $urandom_range(8, 0) - 32'd4;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_body();
    send_body(pick_velocity(), pick_velocity(), pick_angle(),
              $urandom_range(7, 0) == 0);
  endtask

  // Drop valid and wait until every outstanding result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (rotations_due.size() != 0);
  endtask

  // Receiver: always ready, choppy with occasional long stalls, or a fixed
  // duty pattern. One assignment per edge.
  always @(posedge clk) begin
    case (rx_mode)
      RX_CHOPPY: begin
        if (rx_stall_left > 0) begin
          rx_stall_left <= rx_stall_left - 1;
          out_ready     <= 1'b0;
        end else if ($urandom_range(31, 0) == 0) begin
          rx_stall_left <= $urandom_range(40, 5);
          out_ready     <= 1'b0;
        end else begin
          out_ready <= ($urandom_range(3, 0) != 0);
        end
      end
      RX_PERIODIC: out_ready <= ((cycle_count % 13) >= 5);
      default:     out_ready <= 1'b1;
    endcase
  end

  // Check every result transaction against the oldest prediction.
  always @(posedge clk) begin : check_results
    rotated_t due;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (rotations_due.size() == 0) begin
        flag_mismatch("unexpected result rot_x", rot_x, 32'd0);
      end else begin
        due = rotations_due.pop_front();
        if (rot_x !== due.x) flag_mismatch("rot_x", rot_x, due.x);
        if (rot_y !== due.y) flag_mismatch("rot_y", rot_y, due.y);
        if (result_last !== due.last)
          flag_mismatch("result_last", {31'd0, result_last}, {31'd0, due.last});
      end
    end
  end

  // Watchdog: end the run if the DUT hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $realtime,
               rotations_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Quadrant fold: axes, the exact eighth-turn tie that rounds up to the next
  // quadrant, the wrap back to quadrant zero, and the top of the angle range.
  task automatic test_quadrant_fold();
    rx_mode   = RX_ALWAYS;
    gap_limit = 0;
    send_body(ONE_Q16 + ONE_Q16 / 2, -ONE_Q16 * 3 / 4, 32'h0000_0000, 1'b0);
    send_body(ONE_Q16 + ONE_Q16 / 2, -ONE_Q16 * 3 / 4, EIGHTH_TURN - 32'd1, 1'b0);
    send_body(ONE_Q16 + ONE_Q16 / 2, -ONE_Q16 * 3 / 4, EIGHTH_TURN, 1'b0);
    send_body(ONE_Q16 + ONE_Q16 / 2, -ONE_Q16 * 3 / 4, QUARTER_TURN, 1'b0);
    send_body(ONE_Q16 + ONE_Q16 / 2, -ONE_Q16 * 3 / 4, HALF_TURN, 1'b0);
    send_body(ONE_Q16 + ONE_Q16 / 2, -ONE_Q16 * 3 / 4, 32'hC000_0000, 1'b0);
    send_body(ONE_Q16 + ONE_Q16 / 2, -ONE_Q16 * 3 / 4, 32'hDFFF_FFFF, 1'b0);
    send_body(ONE_Q16 + ONE_Q16 / 2, -ONE_Q16 * 3 / 4, 32'hE000_0000, 1'b0);
    send_body(ONE_Q16 + ONE_Q16 / 2, -ONE_Q16 * 3 / 4, 32'hFFFF_FFFF, 1'b1);
  endtask

  // Full-scale inputs: rotations near odd multiples of 45 degrees push past the
  // range and must clamp; the most negative value must not wrap.
  task automatic test_full_scale();
    send_body(VEL_MAX, VEL_MAX, EIGHTH_TURN - 32'd1, 1'b0);
    send_body(VEL_MIN, VEL_MIN, EIGHTH_TURN - 32'd1, 1'b0);
    send_body(VEL_MAX, VEL_MIN, 32'h6000_0000, 1'b0);
    send_body(VEL_MIN, VEL_MAX, 32'hA000_0000, 1'b0);
    send_body(VEL_MIN, 32'sd0, 32'h0000_0000, 1'b0);
    send_body(32'sd0, VEL_MIN, QUARTER_TURN, 1'b0);
    send_body(VEL_MIN, VEL_MIN, HALF_TURN, 1'b1);
  endtask

  // Zero and one-LSB vectors, and both values of the last flag.
  task automatic test_small_vectors();
    send_body(32'sd0, 32'sd0, $urandom, 1'b1);
    send_body(32'sd1, -32'sd1, $urandom, 1'b0);
    send_body(-32'sd1, -32'sd1, EIGHTH_TURN, 1'b1);
    send_body(32'sd1, 32'sd0, QUARTER_TURN + 32'd1, 1'b0);
    send_body(-32'sd1, 32'sd1, 32'hFFFF_FFFF, 1'b1);
  endtask

  // No idling on either side: the pipe runs at full rate.
  task automatic test_back_to_back(input int count);
    rx_mode   = RX_ALWAYS;
    gap_limit = 0;
    repeat (count) send_random_body();
  endtask

  // Bursty sender against a choppy receiver.
  task automatic test_bursty_traffic(input int count);
    rx_mode     = RX_CHOPPY;
    gap_limit   = 12;
    burst_limit = 20;
    burst_left  = 0;
    repeat (count) send_random_body();
  endtask

  // Hold the sender off until every outstanding result is back, four times.
  task automatic test_drain_pause(input int count);
    rx_mode     = RX_PERIODIC;
    gap_limit   = 6;
    burst_limit = 30;
    burst_left  = 0;
    repeat (4) begin
      repeat (count / 4) send_random_body();
      drain_results();
    end
  endtask

  // Tight sender against a periodic, then a choppy, stalling receiver.
  task automatic test_backpressure(input int count);
    gap_limit   = 2;
    burst_limit = 50;
    burst_left  = 0;
    rx_mode     = RX_PERIODIC;
    repeat (count / 2) send_random_body();
    rx_mode     = RX_CHOPPY;
    repeat (count / 2) send_random_body();
  endtask

  initial begin
    gain_k = cordic_gain();
    // Hold reset, then release it on a rising edge.
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_quadrant_fold();
    test_full_scale();
    test_small_vectors();
    test_back_to_back(300);
    test_bursty_traffic(700);
    test_drain_pause(200);
    test_backpressure(450);

    // Let the pipe flush, then watch for stray results.
    rx_mode = RX_ALWAYS;
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/vr2d_pkg.sv
design/vr2d_cell.sv
design/vr2d_mix.sv
design/vector_rotate_2d_unit.sv
tb/sv/vector_rotate_2d_unit_tb.sv
